FILE: src/smudge_brush_blend_assert.svh
`ifndef SMUDGE_BRUSH_BLEND_ASSERT_SVH
`define SMUDGE_BRUSH_BLEND_ASSERT_SVH
// Assertion macros for the smudge brush blend block; clock and reset are the module's own.
`define SBB_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("smudge brush blend: assertion failed");
`define SBB_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("smudge brush blend: assertion failed");
`endif

FILE: src/sbb_pkg.sv
// Shared types and constants of the smudge brush blend block.
package sbb_pkg;
   localparam logic [1:0] MODE_SEED  = 2'd0;
   localparam logic [1:0] MODE_SMEAR = 2'd1;
   localparam logic [1:0] MODE_END   = 2'd2;

   localparam logic CSR_DIAMETER = 1'b0;
   localparam logic CSR_STRENGTH = 1'b1;
   localparam int   CSR_WIDTH    = 7;
   localparam int   POS_WIDTH    = 8;

   localparam logic [6:0] DIAMETER_RESET = 7'd10;
   localparam logic [3:0] LEVEL_RESET    = 4'd5;
   localparam logic [3:0] LEVEL_MIN      = 4'd1;
   localparam logic [3:0] LEVEL_MAX      = 4'd10;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] pixel_argb;
   } req_type;

   typedef struct packed {
      logic [31:0] blended_argb;
      logic [5:0]  col;
      logic [5:0]  row;
      logic        last_of_patch;
   } rsp_type;

   typedef struct packed {
      logic                 smear;
      logic [POS_WIDTH-1:0] col;
      logic [POS_WIDTH-1:0] row;
      logic                 last;
      logic [31:0]          pixel;
   } job_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] half;
      logic [3:0]           level;
   } cfg_type;

   typedef struct packed {
      logic                 carry;
      logic [POS_WIDTH-1:0] col;
      logic [POS_WIDTH-1:0] row;
   } front_stat_type;
endpackage

FILE: src/sbb_front.sv
// Front end: config registers, patch position counters, mode decode and job issue.
module sbb_front import sbb_pkg::*; #(
   parameter int MAX_DIAMETER = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output job_type              q_data,
   output cfg_type              cfg,
   output front_stat_type       stat
);
   localparam int CW = $clog2(MAX_DIAMETER);
   localparam int DW = CW + 1;

   logic [6:0]    diameter_ff;
   logic [3:0]    level_ff;
   logic          carry_ff, carry_in;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [DW-1:0] eff_d;
   logic [3:0]    eff_level;
   logic          accept, step, col_wrap, row_wrap, last;

   always_comb begin
      if (diameter_ff < 7'd2) begin
         eff_d = DW'(2);
      end else if (9'(diameter_ff) > 9'(MAX_DIAMETER)) begin
         eff_d = DW'(MAX_DIAMETER);
      end else begin
         eff_d = DW'(diameter_ff);
      end
      if (level_ff < LEVEL_MIN) begin
         eff_level = LEVEL_MIN;
      end else if (level_ff > LEVEL_MAX) begin
         eff_level = LEVEL_MAX;
      end else begin
         eff_level = level_ff;
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign col_wrap  = (DW'(col_ff) + DW'(1)) >= eff_d;
   assign row_wrap  = (DW'(row_ff) + DW'(1)) >= eff_d;
   assign last      = (DW'(col_ff) == eff_d - DW'(1)) && (DW'(row_ff) == eff_d - DW'(1));

   always_comb begin
      carry_in = carry_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      q_push   = 1'b0;
      step     = 1'b0;
      if (accept) begin
         case (req_data.mode)
            MODE_SEED: begin
               q_push   = 1'b1;
               carry_in = 1'b1;
               step     = 1'b1;
            end
            MODE_SMEAR: begin
               // smear without a carried buffer is dropped and does not move
               q_push = carry_ff;
               step   = carry_ff;
            end
            MODE_END: begin
               carry_in = 1'b0;
               col_in   = '0;
               row_in   = '0;
            end
            default: ;
         endcase
         if (step) begin
            if (col_wrap) begin
               col_in = '0;
               row_in = row_wrap ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      q_data.smear = (req_data.mode == MODE_SMEAR);
      q_data.col   = POS_WIDTH'(col_ff);
      q_data.row   = POS_WIDTH'(row_ff);
      q_data.last  = last;
      q_data.pixel = req_data.pixel_argb;
      cfg.half     = POS_WIDTH'(eff_d >> 1);
      cfg.level    = eff_level;
      stat.carry   = carry_ff;
      stat.col     = POS_WIDTH'(col_ff);
      stat.row     = POS_WIDTH'(row_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diameter_ff <= DIAMETER_RESET;
         level_ff    <= LEVEL_RESET;
         carry_ff    <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         carry_ff <= carry_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (csr_we) begin
            case (csr_index)
               CSR_DIAMETER: diameter_ff <= csr_wdata;
               CSR_STRENGTH: level_ff    <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end
endmodule

FILE: src/sbb_queue.sv
// Four-entry job queue between front and back ends.
module sbb_queue import sbb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    full,
   output logic    empty
);
   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   job_type       entry_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   count_ff;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end
endmodule

FILE: src/sbb_back.sv
// Back end: radius pipeline (sqrt, divide), weight, carried buffer and blend.
module sbb_back import sbb_pkg::*; #(
   parameter int MAX_DIAMETER = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_empty,
   output logic    q_pop,
   input  job_type q_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int CW    = $clog2(MAX_DIAMETER);
   localparam int SW    = 2 * CW + 1;
   localparam int RW    = CW + 17;
   localparam int RADW  = 2 * RW;
   localparam int NSQ   = (RW + 1) / 2;
   localparam int NA    = 2 * NSQ;
   localparam int DEPTH = MAX_DIAMETER * MAX_DIAMETER;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [16:0] ONE16 = 17'h10000;

   typedef struct packed {
      logic          valid;
      logic          smear;
      logic          in_circle;
      logic [CW-1:0] col;
      logic [CW-1:0] row;
      logic          last;
      logic [31:0]   pixel;
      logic [AW-1:0] addr;
   } ctx_type;

   typedef struct packed {
      ctx_type         ctx;
      logic [RADW-1:0] rad;
      logic [RW+2:0]   rem;
      logic [RW-1:0]   root;
      logic [CW:0]     drem;
      logic [RW-1:0]   dq;
   } stage_type;

   function automatic logic [16:0] str16_of(input logic [3:0] level);
      case (level)
         4'd1:    str16_of = 17'd6553;
         4'd2:    str16_of = 17'd13107;
         4'd3:    str16_of = 17'd19660;
         4'd4:    str16_of = 17'd26214;
         4'd5:    str16_of = 17'd32768;
         4'd6:    str16_of = 17'd39321;
         4'd7:    str16_of = 17'd45875;
         4'd8:    str16_of = 17'd52428;
         4'd9:    str16_of = 17'd58982;
         default: str16_of = 17'd65536;
      endcase
   endfunction

   // pickup rate, 0.04 per level
   function automatic logic [16:0] p16_of(input logic [3:0] level);
      case (level)
         4'd1:    p16_of = 17'd2621;
         4'd2:    p16_of = 17'd5242;
         4'd3:    p16_of = 17'd7864;
         4'd4:    p16_of = 17'd10485;
         4'd5:    p16_of = 17'd13107;
         4'd6:    p16_of = 17'd15728;
         4'd7:    p16_of = 17'd18350;
         4'd8:    p16_of = 17'd20971;
         4'd9:    p16_of = 17'd23592;
         default: p16_of = 17'd26214;
      endcase
   endfunction

   function automatic logic [31:0] mix_argb(input logic [31:0] a, input logic [31:0] b,
                                            input logic [16:0] wa);
      logic [31:0] res;
      logic [24:0] v;
      logic [16:0] wb;
      wb = 17'(18'h10000 - 18'(wa));
      for (int i = 0; i < 4; i++) begin
         v = 25'(a[8*i +: 8]) * 25'(wa) + 25'(b[8*i +: 8]) * 25'(wb);
         res[8*i +: 8] = v[23:16];
      end
      return res;
   endfunction

   logic          adv;
   logic [CW-1:0] half, col0, row0;
   logic signed [CW:0]     dx, dy;
   logic signed [2*CW+1:0] px, py;
   logic [SW-1:0]   s;
   logic [2*CW-1:0] hh;
   logic            inside0;

   stage_type st_ff [NA+1];
   stage_type st_in [NA+1];

   ctx_type       w1_ctx_ff, w2_ctx_ff, m1_ctx_ff;
   logic [33:0]   w1_tt_ff;
   logic [34:0]   w2_prod_ff;
   logic [16:0]   m1_a16_ff;
   logic [RW-1:0] q_clamp;
   logic [16:0]   t16, a16;
   logic [33:0]   tt;
   logic [34:0]   prod;
   logic [18:0]   a_raw;

   logic [31:0] carry_mem_ff [DEPTH];
   logic [31:0] mem_rd_ff, fwd_data_ff, buf_px, wr_data, blend;
   logic        fwd_hit_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && !q_empty;
   assign half  = CW'(cfg.half);

   // distance squared from the patch center
   always_comb begin
      col0    = CW'(q_data.col);
      row0    = CW'(q_data.row);
      dx      = $signed({1'b0, col0}) - $signed({1'b0, half});
      dy      = $signed({1'b0, row0}) - $signed({1'b0, half});
      px      = dx * dx;
      py      = dy * dy;
      s       = SW'(px[2*CW-1:0]) + SW'(py[2*CW-1:0]);
      hh      = half * half;
      inside0 = s <= SW'(hh);

      st_in[0].ctx.valid     = !q_empty;
      st_in[0].ctx.smear     = q_data.smear;
      st_in[0].ctx.in_circle = inside0;
      st_in[0].ctx.col       = col0;
      st_in[0].ctx.row       = row0;
      st_in[0].ctx.last      = q_data.last;
      st_in[0].ctx.pixel     = q_data.pixel;
      st_in[0].ctx.addr      = AW'(32'(row0) * MAX_DIAMETER + 32'(col0));
      st_in[0].rad           = inside0 ? RADW'({s, 32'd0}) : '0;
      st_in[0].rem           = '0;
      st_in[0].root          = '0;
      st_in[0].drem          = '0;
      st_in[0].dq            = '0;
   end

   // two sqrt digits per stage, then two quotient bits per stage
   for (genvar k = 0; k < NA; k++) begin : g_stage
      always_comb begin
         stage_type     x;
         logic [RW+2:0] trial;
         logic [CW+1:0] t;
         x = st_ff[k];
         trial = '0;
         t = '0;
         if (k == NSQ) begin
            x.dq   = x.root;
            x.drem = '0;
         end
         for (int j = 0; j < 2; j++) begin
            if (k < NSQ) begin
               if (2 * k + j < RW) begin
                  x.rem = {x.rem[RW:0], x.rad[RADW-1 -: 2]};
                  x.rad = x.rad << 2;
                  trial = {1'b0, x.root, 2'b01};
                  if (x.rem >= trial) begin
                     x.rem  = x.rem - trial;
                     x.root = {x.root[RW-2:0], 1'b1};
                  end else begin
                     x.root = {x.root[RW-2:0], 1'b0};
                  end
               end
            end else begin
               if (2 * (k - NSQ) + j < RW) begin
                  t    = {x.drem, x.dq[RW-1]};
                  x.dq = x.dq << 1;
                  if (t >= (CW+2)'(half)) begin
                     x.drem  = (CW+1)'(t - (CW+2)'(half));
                     x.dq[0] = 1'b1;
                  end else begin
                     x.drem = t[CW:0];
                  end
               end
            end
         end
         st_in[k+1] = x;
      end
   end

   always_comb begin
      q_clamp = (st_ff[NA].dq > RW'(ONE16)) ? RW'(ONE16) : st_ff[NA].dq;
      t16     = 17'(18'h10000 - 18'(q_clamp));
      tt      = 34'(t16) * 34'(t16);
      prod    = 35'(w1_tt_ff[33:16]) * 35'(str16_of(cfg.level));
      a_raw   = w2_prod_ff[34:16];
      a16     = (a_raw > 19'(ONE16)) ? ONE16 : 17'(a_raw);
   end

   always_comb begin
      buf_px  = fwd_hit_ff ? fwd_data_ff : mem_rd_ff;
      wr_data = m1_ctx_ff.smear ? mix_argb(m1_ctx_ff.pixel, buf_px, p16_of(cfg.level))
                                : m1_ctx_ff.pixel;
      blend   = m1_ctx_ff.in_circle ? mix_argb(buf_px, m1_ctx_ff.pixel, m1_a16_ff)
                                    : m1_ctx_ff.pixel;
   end

   // read-first memory; the write in flight is forwarded to the next reader
   always_ff @(posedge clock) begin
      if (adv) begin
         mem_rd_ff   <= carry_mem_ff[w2_ctx_ff.addr];
         fwd_data_ff <= wr_data;
         if (m1_ctx_ff.valid) begin
            carry_mem_ff[m1_ctx_ff.addr] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NA; i++) begin
            st_ff[i].ctx.valid <= 1'b0;
         end
         w1_ctx_ff.valid <= 1'b0;
         w2_ctx_ff.valid <= 1'b0;
         m1_ctx_ff.valid <= 1'b0;
         fwd_hit_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i <= NA; i++) begin
            st_ff[i] <= st_in[i];
         end
         w1_ctx_ff    <= st_ff[NA].ctx;
         w1_tt_ff     <= tt;
         w2_ctx_ff    <= w1_ctx_ff;
         w2_prod_ff   <= prod;
         m1_ctx_ff    <= w2_ctx_ff;
         m1_a16_ff    <= a16;
         fwd_hit_ff   <= m1_ctx_ff.valid && (m1_ctx_ff.addr == w2_ctx_ff.addr);
         rsp_valid_ff <= m1_ctx_ff.valid && m1_ctx_ff.smear;
         rsp_data_ff.blended_argb  <= blend;
         rsp_data_ff.col           <= 6'(m1_ctx_ff.col);
         rsp_data_ff.row           <= 6'(m1_ctx_ff.row);
         rsp_data_ff.last_of_patch <= m1_ctx_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

FILE: src/smudge_brush_blend.sv
// Throughput: one transaction per cycle unless rsp_ready holds the pipeline; sqrt and divide
// are pipelined two bits a stage, and the carried buffer is read and written once per item,
// read from the w2 stage and written from the m1 stage.
// Seed, end, unused-mode and dropped smear transactions give no rsp; a four-entry queue decouples req.
// Reset (synchronous, active high) clears counters, carry flag and pipeline valids and
// loads diameter 10 and strength level 5; the carried buffer is not cleared.
`include "smudge_brush_blend_assert.svh"
module smudge_brush_blend import sbb_pkg::*; #(
   parameter int MAX_DIAMETER = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);
   logic           q_push, q_pop, q_full, q_empty;
   job_type        q_in, q_out;
   cfg_type        cfg;
   front_stat_type fstat;

   sbb_front #(.MAX_DIAMETER(MAX_DIAMETER)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in),
      .cfg       (cfg),
      .stat      (fstat)
   );

   sbb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   sbb_back #(.MAX_DIAMETER(MAX_DIAMETER)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_out),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `SBB_ASSERT_NEXT(a_end_clears, req_valid && req_ready && req_data.mode == MODE_END, !fstat.carry && fstat.col == '0 && fstat.row == '0)
   `SBB_ASSERT_NEXT(a_seed_sets_carry, req_valid && req_ready && req_data.mode == MODE_SEED, fstat.carry)
   `SBB_ASSERT_SAME(a_queue_no_overflow, q_full, !q_push)
   `SBB_ASSERT_SAME(a_last_on_diagonal, rsp_valid && rsp_data.last_of_patch, rsp_data.col == rsp_data.row)
endmodule

FILE: test/smudge_brush_blend_check.sv
// Checker for the smudge brush blend block: watches the channels, predicts and compares.
`timescale 1ns / 100ps
module smudge_brush_blend_check import sbb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   output int                   failures,
   output int                   pending
);
   localparam int MAXD = 64;
   localparam logic [16:0] UNIT = 17'h10000;

   logic [31:0] smear_buf [MAXD*MAXD];
   logic        have_buf;
   int          cur_col, cur_row;
   logic [6:0]  diam_reg;
   logic [3:0]  level_reg;
   rsp_type     blend_queue[$];

   assign pending = blend_queue.size();

   function automatic int clip_diam();
      if (diam_reg < 2) return 2;
      if (diam_reg > MAXD) return MAXD;
      return diam_reg;
   endfunction

   function automatic int clip_level();
      if (level_reg < LEVEL_MIN) return LEVEL_MIN;
      if (level_reg > LEVEL_MAX) return LEVEL_MAX;
      return level_reg;
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, bit_q;
      res = 0;
      bit_q = 64'd1 << 62;
      while (bit_q > v) bit_q = bit_q >> 2;
      while (bit_q != 0) begin
         if (v >= res + bit_q) begin
            v = v - (res + bit_q);
            res = (res >> 1) + bit_q;
         end else begin
            res = res >> 1;
         end
         bit_q = bit_q >> 2;
      end
      return res;
   endfunction

   // per channel floor((a*wa + b*(1-wa)) / 2^16)
   function automatic logic [31:0] mix_pixel(logic [31:0] a, logic [31:0] b, logic [63:0] wa);
      logic [31:0] out;
      logic [63:0] v;
      out = 0;
      for (int sh = 0; sh < 32; sh += 8) begin
         v = ((64'(a[sh +: 8]) * wa) + (64'(b[sh +: 8]) * (64'(UNIT) - wa))) >> 16;
         if (v > 255) v = 255;
         out[sh +: 8] = v[7:0];
      end
      return out;
   endfunction

   task automatic step_counters(int d);
      if (cur_col + 1 >= d) begin
         cur_col = 0;
         cur_row = (cur_row + 1 >= d) ? 0 : cur_row + 1;
      end else begin
         cur_col++;
      end
   endtask

   task automatic predict_blend(req_type item);
      int d, lvl, half, dx, dy, idx;
      logic [63:0] s, d16, q16, t16, a16, str16, p16;
      logic [31:0] held, res;
      rsp_type expect_rsp;
      d = clip_diam();
      idx = (cur_row * MAXD + cur_col) % (MAXD * MAXD);
      case (item.mode)
         MODE_END: begin
            have_buf = 1'b0;
            cur_col = 0;
            cur_row = 0;
         end
         MODE_SEED: begin
            smear_buf[idx] = item.pixel_argb;
            have_buf = 1'b1;
            step_counters(d);
         end
         MODE_SMEAR: begin
            if (have_buf) begin
               lvl = clip_level();
               half = d / 2;
               dx = cur_col - half;
               dy = cur_row - half;
               s = 64'(dx * dx + dy * dy);
               held = smear_buf[idx];
               res = item.pixel_argb;
               p16 = (64'(lvl) * 4 * 65536) / 100;
               if (s <= 64'(half * half)) begin
                  d16 = root64(s << 32);
                  q16 = d16 / half;
                  if (q16 > UNIT) q16 = UNIT;
                  t16 = UNIT - q16;
                  str16 = (64'(lvl) * 65536) / 10;
                  a16 = (((t16 * t16) >> 16) * str16) >> 16;
                  if (a16 > UNIT) a16 = UNIT;
                  res = mix_pixel(held, item.pixel_argb, a16);
               end
               smear_buf[idx] = mix_pixel(item.pixel_argb, held, p16);
               expect_rsp.blended_argb = res;
               expect_rsp.col = cur_col[5:0];
               expect_rsp.row = cur_row[5:0];
               expect_rsp.last_of_patch = (cur_col == d - 1 && cur_row == d - 1);
               blend_queue.push_back(expect_rsp);
               step_counters(d);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_blend(rsp_type got);
      rsp_type want;
      if (blend_queue.size() == 0) begin
         $error("unexpected transaction on rsp: %h", got);
         failures++;
         return;
      end
      want = blend_queue.pop_front();
      if (got.blended_argb !== want.blended_argb) begin
         $error("blended_argb: expected %h, actual %h", want.blended_argb, got.blended_argb);
         failures++;
      end
      if (got.col !== want.col) begin
         $error("col: expected %0d, actual %0d", want.col, got.col);
         failures++;
      end
      if (got.row !== want.row) begin
         $error("row: expected %0d, actual %0d", want.row, got.row);
         failures++;
      end
      if (got.last_of_patch !== want.last_of_patch) begin
         $error("last_of_patch: expected %0d, actual %0d",
                want.last_of_patch, got.last_of_patch);
         failures++;
      end
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      if (reset) begin
         have_buf <= 1'b0;
         cur_col <= 0;
         cur_row <= 0;
         diam_reg <= DIAMETER_RESET;
         level_reg <= LEVEL_RESET;
         blend_queue.delete();
      end else begin
         // a transaction on the same edge as a register write still sees the old setting
         if (req_valid && req_ready) predict_blend(req_data);
         if (rsp_valid && rsp_ready) compare_blend(rsp_data);
         if (csr_we) begin
            if (csr_index == CSR_DIAMETER) diam_reg = csr_wdata[6:0];
            else level_reg = csr_wdata[3:0];
         end
      end
   end
endmodule

FILE: test/smudge_brush_blend_test.sv
// Top of the smudge brush blend testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module smudge_brush_blend_test;
   import sbb_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int MAXD = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic                 csr_index = CSR_DIAMETER;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;
   int                   failures, pending;
   int                   cycles = 0;

   // sender-side copy of position and buffer coverage, kept so no smear reads an unseeded entry
   logic                 seeded [MAXD*MAXD];
   logic                 carry_on = 1'b0;
   int                   pos_col = 0, pos_row = 0;
   int                   diam_now = 10;
   logic                 quiet = 1'b0;
   logic                 hold_req = 1'b0;

   smudge_brush_blend u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   smudge_brush_blend_check u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request, none when quiet
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_req <= 1'b0;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic [1:0] mode, logic [31:0] pixel);
      int idx;
      idx = (pos_row * MAXD + pos_col) % (MAXD * MAXD);
      if (mode == MODE_SMEAR && carry_on && !seeded[idx]) mode = MODE_SEED;
      req_valid <= 1'b1;
      req_data <= '{mode: mode, pixel_argb: pixel};
      do @(posedge clock); while (!req_ready);
      case (mode)
         MODE_END: begin
            carry_on = 1'b0;
            pos_col = 0;
            pos_row = 0;
         end
         MODE_SEED, MODE_SMEAR: begin
            if (mode == MODE_SEED) begin
               seeded[idx] = 1'b1;
               carry_on = 1'b1;
            end
            if (mode == MODE_SEED || carry_on) begin
               if (pos_col + 1 >= diam_now) begin
                  pos_col = 0;
                  pos_row = (pos_row + 1 >= diam_now) ? 0 : pos_row + 1;
               end else begin
                  pos_col++;
               end
            end
         end
         default: ;
      endcase
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // reprogram only once the pipeline has drained
   task automatic set_brush(logic [6:0] diam, logic [3:0] level);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_DIAMETER;
      csr_wdata <= diam;
      @(posedge clock);
      csr_index <= CSR_STRENGTH;
      csr_wdata <= 7'(level);
      @(posedge clock);
      csr_we <= 1'b0;
      diam_now = (diam < 2) ? 2 : (diam > MAXD) ? MAXD : diam;
   endtask

   task automatic run_strokes(int count);
      int sent, seeds;
      int r;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) != 0) begin
            send_item(MODE_END, $urandom);
            sent++;
         end
         seeds = $urandom_range(1, (diam_now * diam_now > 80) ? 80 : diam_now * diam_now);
         // keep the total near the requested count
         if (seeds > count - sent) seeds = count - sent;
         repeat (seeds) send_item(MODE_SEED, pick_pixel());
         sent += seeds;
         if ($urandom_range(0, 2) != 0) begin
            send_item(MODE_END, $urandom);
            sent++;
         end
         repeat ($urandom_range(4, 60)) begin
            if (sent >= count) break;
            r = $urandom_range(0, 99);
            if (r < 82) send_item(MODE_SMEAR, pick_pixel());
            else if (r < 90) send_item(MODE_SEED, pick_pixel());
            else if (r < 95) send_item(MODE_END, pick_pixel());
            else send_item(MODE_UNUSED, pick_pixel());
            sent++;
         end
      end
   endtask

   initial begin
      foreach (seeded[i]) seeded[i] = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: tiny patch, smear with no buffer, unused mode, extreme pixels
      set_brush(7'd2, 4'd10);
      send_item(MODE_SMEAR, 32'hFFFF_FFFF);
      send_item(MODE_UNUSED, 32'hFFFF_FFFF);
      send_item(MODE_SEED, 32'h0);
      send_item(MODE_SEED, 32'hFFFF_FFFF);
      send_item(MODE_SEED, 32'h8080_8080);
      send_item(MODE_SEED, 32'h1234_5678);
      send_item(MODE_SMEAR, 32'hFFFF_FFFF);
      send_item(MODE_SMEAR, 32'h0);
      send_item(MODE_SMEAR, 32'hFFFF_FFFF);
      send_item(MODE_SMEAR, 32'h0);
      send_item(MODE_SMEAR, 32'hA5A5_A5A5);
      send_item(MODE_END, 32'h0);
      send_item(MODE_SMEAR, 32'h5A5A_5A5A);

      run_strokes(120);
      set_brush(7'd64, 4'd1);
      hold_req <= 1'b1;
      run_strokes(160);
      set_brush(7'd0, 4'd0);
      run_strokes(100);
      set_brush(7'd127, 4'd15);
      run_strokes(120);
      set_brush(7'd3, 4'd7);
      run_strokes(150);
      set_brush(7'd1, 4'd11);
      run_strokes(80);
      set_brush(7'd9, 4'd3);
      run_strokes(150);
      set_brush(7'd5, 4'd10);
      quiet <= 1'b1;
      run_strokes(150);
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
